// File: hw/rtl/incremental_pid_controller_core_macros.svh
// ---------------------------------------------------------------------------
// Incremental PID controller assertion macros
// Concurrent assertion wrappers shared by the RTL files; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH
`define INCREMENTAL_PID_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on clk, masked while rst_n is low
`define IPID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk, also during reset
`define IPID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IPID_ASSERT(lbl, prop, msg)

`define IPID_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/ipid_pkg.sv
// ---------------------------------------------------------------------------
// Incremental PID controller package
// Widths, operation and register codes, and the structs passed between units.
// ---------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 12;
    localparam int LIMIT_W    = 15;
    localparam int OPCODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;
    localparam int STARTUP_W  = 2;

    // Datapath widths: error, combined coefficient, product, sum, shifted sum, output sum
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int COEF_W    = GAIN_W + 2;
    localparam int PROD_W    = COEF_W + ERR_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int SHIFT_W   = ACC_W - GAIN_FRAC;
    localparam int OUT_SUM_W = SHIFT_W + 1;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_UPDATE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PRELOAD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT_DT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DER_DT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_OUTPUT = 3'd4;

    // Reset values
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET       = 15'h7fff;
    localparam logic [SAMPLE_W-1:0] INIT_OUTPUT_RESET = 16'h0000;

    // Number of proportional-only updates after a restart
    localparam logic [STARTUP_W-1:0] STARTUP_DONE = 2'd2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_int_dt;
        logic signed [GAIN_W-1:0] gain_der_dt;
        logic [LIMIT_W-1:0]       output_limit;
    } ipid_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_output;
        logic signed [ERR_W-1:0]    prev_error;
        logic signed [ERR_W-1:0]    prev_prev_error;
        logic [STARTUP_W-1:0]       startup_cnt;
    } ipid_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] measurement;
        logic signed [SAMPLE_W-1:0] preload_output;
    } ipid_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/ipid_step.sv
// ---------------------------------------------------------------------------
// Incremental PID step
// Next controller state for one word: velocity-form update, clear or preload.
// ---------------------------------------------------------------------------
`default_nettype none

module ipid_step (
    input  ipid_pkg::ipid_cfg_t   cfg,
    input  ipid_pkg::ipid_state_t state_cur,
    input  ipid_pkg::ipid_item_t  item,
    output ipid_pkg::ipid_state_t state_next
);

    import ipid_pkg::*;

    logic                        startup;
    logic signed [ERR_W-1:0]     err;
    logic signed [COEF_W-1:0]    coef0;
    logic signed [COEF_W-1:0]    coef1;
    logic signed [COEF_W-1:0]    coef2;
    logic signed [PROD_W-1:0]    prod0;
    logic signed [PROD_W-1:0]    prod1;
    logic signed [PROD_W-1:0]    prod2;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SHIFT_W-1:0]   acc_shift;
    logic signed [OUT_SUM_W-1:0] out_sum;
    logic signed [OUT_SUM_W-1:0] lim_pos;
    logic signed [OUT_SUM_W-1:0] lim_neg;
    logic signed [SAMPLE_W-1:0]  out_clamped;

    // Form the error
    assign err = ERR_W'(item.setpoint) - ERR_W'(item.measurement);

    // Select coefficients: proportional only during startup
    assign startup = (state_cur.startup_cnt < STARTUP_DONE);

    always_comb
    begin
        if (startup)
        begin
            coef0 = COEF_W'(cfg.gain_prop);
            coef1 = '0;
            coef2 = '0;
        end
        else
        begin
            coef0 = COEF_W'(cfg.gain_prop) + COEF_W'(cfg.gain_int_dt)
                  + COEF_W'(cfg.gain_der_dt);
            coef1 = COEF_W'(cfg.gain_prop) + (COEF_W'(cfg.gain_der_dt) <<< 1);
            coef2 = COEF_W'(cfg.gain_der_dt);
        end
    end

    // Three independent products, summed exactly
    assign prod0 = PROD_W'(coef0) * PROD_W'(err);
    assign prod1 = PROD_W'(coef1) * PROD_W'(state_cur.prev_error);
    assign prod2 = PROD_W'(coef2) * PROD_W'(state_cur.prev_prev_error);
    assign acc   = ACC_W'(prod0) - ACC_W'(prod1) + ACC_W'(prod2);

    // Drop fraction bits (floor), add previous output, clamp
    assign acc_shift = $signed(acc[ACC_W-1:GAIN_FRAC]);
    assign out_sum   = OUT_SUM_W'(acc_shift) + OUT_SUM_W'(state_cur.prev_output);
    assign lim_pos   = $signed({{(OUT_SUM_W-LIMIT_W){1'b0}}, cfg.output_limit});
    assign lim_neg   = -lim_pos;

    always_comb
    begin
        if (out_sum > lim_pos)
        begin
            out_clamped = lim_pos[SAMPLE_W-1:0];
        end
        else if (out_sum < lim_neg)
        begin
            out_clamped = lim_neg[SAMPLE_W-1:0];
        end
        else
        begin
            out_clamped = out_sum[SAMPLE_W-1:0];
        end
    end

    // Apply the operation
    always_comb
    begin
        state_next = state_cur;
        case (item.opcode)
            OP_UPDATE:
            begin
                state_next.prev_output     = out_clamped;
                state_next.prev_error      = err;
                state_next.prev_prev_error = state_cur.prev_error;
                if (startup)
                begin
                    state_next.startup_cnt = state_cur.startup_cnt + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                state_next.prev_output     = '0;
                state_next.prev_error      = '0;
                state_next.prev_prev_error = '0;
                state_next.startup_cnt     = '0;
            end
            OP_PRELOAD:
            begin
                state_next.prev_output = item.preload_output;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/incremental_pid_controller_core.sv
// ---------------------------------------------------------------------------
// Incremental PID controller core
// Velocity-form PID with clamped output, history clear and output preload.
// ---------------------------------------------------------------------------
//   channel   handshake               payload
//   input     in_valid / in_ready     opcode, setpoint, measurement,
//                                     preload_output
//   output    out_valid / out_ready   control_output
//   config    cfg_we                  cfg_index, cfg_data
//
// One word per cycle unless the result register stalls. The input
// register feeds one pass of three parallel multiplies, a sum, and a clamp;
// controller state updates as the word enters the result register. Reset
// clears the handshake and loads the register defaults; no clearing pass.
// A stalled result register holds the input register, and in_ready drops
// once both are full.
`default_nettype none

`include "incremental_pid_controller_core_macros.svh"

module incremental_pid_controller_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ipid_pkg::OPCODE_W-1:0]         opcode,
    input  logic signed [ipid_pkg::SAMPLE_W-1:0]  setpoint,
    input  logic signed [ipid_pkg::SAMPLE_W-1:0]  measurement,
    input  logic signed [ipid_pkg::SAMPLE_W-1:0]  preload_output,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ipid_pkg::SAMPLE_W-1:0]  control_output,
    input  logic                                  cfg_we,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import ipid_pkg::*;

    ipid_cfg_t                  cfg_reg;
    ipid_state_t                state_reg;
    ipid_state_t                state_next;
    ipid_item_t                 item_reg;
    logic                       item_valid_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic                       advance;
    logic                       init_write;

    // Move the held word into the result register when it is free
    assign advance    = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !item_valid_reg || advance;
    assign init_write = cfg_we && (cfg_index == REG_INIT_OUTPUT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop    <= '0;
            cfg_reg.gain_int_dt  <= '0;
            cfg_reg.gain_der_dt  <= '0;
            cfg_reg.output_limit <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_PROP:   cfg_reg.gain_prop    <= cfg_data;
                REG_GAIN_INT_DT: cfg_reg.gain_int_dt  <= cfg_data;
                REG_GAIN_DER_DT: cfg_reg.gain_der_dt  <= cfg_data;
                REG_OUT_LIMIT:   cfg_reg.output_limit <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input register: capture an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.opcode         <= opcode;
            item_reg.setpoint       <= setpoint;
            item_reg.measurement    <= measurement;
            item_reg.preload_output <= preload_output;
        end
    end

    // One controller step
    ipid_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next)
    );

    // Controller state; an initial output write loads the previous output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_output     <= INIT_OUTPUT_RESET;
            state_reg.prev_error      <= '0;
            state_reg.prev_prev_error <= '0;
            state_reg.startup_cnt     <= '0;
        end
        else if (init_write)
        begin
            state_reg.prev_output <= cfg_data[SAMPLE_W-1:0];
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= state_next.prev_output;
        end
    end

    assign out_valid      = out_valid_reg;
    assign control_output = out_data_reg;

    // Assertions
    `IPID_ASSERT(a_out_tracks_state,
        advance && !init_write |=> control_output == state_reg.prev_output,
        "result word differs from stored previous output")
    `IPID_ASSERT(a_startup_range,
        state_reg.startup_cnt <= STARTUP_DONE,
        "startup count beyond saturation")
    `IPID_ASSERT(a_clear_history,
        advance && item_reg.opcode == OP_CLEAR && !init_write |=>
            state_reg.prev_error == '0 && state_reg.prev_prev_error == '0 &&
            state_reg.startup_cnt == '0 && state_reg.prev_output == '0,
        "clear left history behind")
    `IPID_ASSERT(a_ready_when_empty,
        !out_valid_reg |-> in_ready,
        "input stalled with an empty result register")

endmodule

`default_nettype wire
